@@ rtl/core/vertex_world_to_screen_projection_unit_macros.svh @@
// assertion macros for the projection unit
// used by the top level only; needs nothing else
`ifndef VERTEX_WORLD_TO_SCREEN_PROJECTION_UNIT_MACROS_SVH
`define VERTEX_WORLD_TO_SCREEN_PROJECTION_UNIT_MACROS_SVH

// condition holds in the same cycle
`define VWSP_CHK_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define VWSP_CHK_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/vwsp_pkg.sv @@
// shared types, codes and saturation helper for the projection unit
// no dependencies
`timescale 1ns / 1ps

package vwsp_pkg;

  localparam int SAT_W       = 72;
  localparam int CFG_W       = 13;
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(32'sh7fff_ffff);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(32'sh8000_0000);

  typedef enum logic [1:0] {
    MODE_MV   = 2'd0,
    MODE_PROJ = 2'd1,
    MODE_VTX  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_VP_X  = 3'd0,
    REG_VP_Y  = 3'd1,
    REG_VP_W  = 3'd2,
    REG_VP_H  = 3'd3,
    REG_SCR_H = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } clip_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] vp_x;
    logic signed [CFG_W-1:0] vp_y;
    logic [CFG_W-1:0]        vp_w;
    logic [CFG_W-1:0]        vp_h;
    logic [CFG_W-1:0]        scr_h;
  } view_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) begin
      return 32'sh7fff_ffff;
    end else if (v < SAT_LO) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

@@ rtl/core/vwsp_front.sv @@
// front end: takes words, holds both matrices, runs the two matrix multiplies
// depends on vwsp_pkg
`timescale 1ns / 1ps

module vwsp_front import vwsp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] vertex_z,
  output clip_t              clip,
  output logic               clip_vld,
  input  logic               q_full
);

  localparam logic signed [31:0] ONE = 32'(1) << FRAC_BITS;

  logic signed [31:0] mv [16];
  logic signed [31:0] pj [16];

  logic s1_vld, s2_vld, s3_vld;
  logic adv, acc;

  logic signed [63:0] p1 [4][3];
  logic signed [31:0] t1 [4];
  logic signed [31:0] eye [4];
  logic signed [63:0] p3 [4][4];
  logic signed [31:0] eye_next [4];
  logic signed [31:0] clip_next [4];
  logic signed [31:0] vtx [3];

  assign adv = !(clip_vld && q_full);
  // a projection load waits while a vertex has not yet taken its eye coordinates
  assign in_ready = adv && !(mode == MODE_PROJ && s1_vld);
  assign acc = in_valid && in_ready;

  assign vtx[0] = vertex_x;
  assign vtx[1] = vertex_y;
  assign vtx[2] = vertex_z;

  always_comb begin
    logic signed [SAT_W-1:0] a;
    for (int i = 0; i < 4; i++) begin
      a = SAT_W'(t1[i]);
      for (int j = 0; j < 3; j++) begin
        a = a + SAT_W'(p1[i][j] >>> FRAC_BITS);
      end
      eye_next[i] = sat32(a);
      a = '0;
      for (int j = 0; j < 4; j++) begin
        a = a + SAT_W'(p3[i][j] >>> FRAC_BITS);
      end
      clip_next[i] = sat32(a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      s3_vld   <= 1'b0;
      clip_vld <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        mv[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE : '0;
        pj[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE : '0;
      end
    end else begin
      if (acc && mode == MODE_MV) begin
        mv[coef_index] <= coef_value;
      end
      if (acc && mode == MODE_PROJ) begin
        pj[coef_index] <= coef_value;
      end
      if (adv) begin
        s1_vld   <= acc && mode == MODE_VTX;
        s2_vld   <= s1_vld;
        s3_vld   <= s2_vld;
        clip_vld <= s3_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        t1[i] <= mv[12 + i];
        for (int j = 0; j < 3; j++) begin
          p1[i][j] <= mv[j * 4 + i] * vtx[j];
        end
        eye[i] <= eye_next[i];
        for (int j = 0; j < 4; j++) begin
          p3[i][j] <= pj[j * 4 + i] * eye[j];
        end
      end
      clip.x <= clip_next[0];
      clip.y <= clip_next[1];
      clip.z <= clip_next[2];
      clip.w <= clip_next[3];
    end
  end

endmodule

@@ rtl/core/vwsp_fifo.sv @@
// short queue of clip coordinates between front and back end
// depends on vwsp_pkg
`timescale 1ns / 1ps

module vwsp_fifo import vwsp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  clip_t   push_data,
  input  logic    pop,
  output clip_t   pop_data,
  output q_stat_t stat
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  clip_t        mem [QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign pop_data   = mem[rp];
  assign stat.full  = (cnt == (AW + 1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

endmodule

@@ rtl/core/vwsp_back.sv @@
// back end: pipelined divide by w, viewport mapping, output register
// depends on vwsp_pkg
`timescale 1ns / 1ps

module vwsp_back import vwsp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  clip_t              clip,
  input  q_stat_t            q_stat,
  output logic               pop,
  input  view_cfg_t          cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic signed [31:0] screen_depth,
  output logic               result_valid
);

  localparam int DW = 32 + FRAC_BITS;  // dividend and quotient bits
  localparam int PW = 33 + DW;         // partial remainder plus quotient
  localparam int NW = 34;
  localparam int MW = 48;
  localparam int OW = 51;
  localparam logic signed [NW-1:0] ONE_N =
    {{(NW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic ben;

  logic          vld  [DW + 1];
  logic          zero [DW + 1];
  logic [2:0]    neg  [DW + 1];
  logic [31:0]   dv   [DW + 1];
  logic [PW-1:0] pr   [DW + 1][3];

  logic                     n_vld, n_zero, m_vld, m_zero;
  logic signed [31:0]       nd [3];
  logic signed [31:0]       nd_next [3];
  logic signed [MW-1:0]     mx, my;
  logic signed [NW-1:0]     ez;
  logic signed [MW-1:0]     mx_next, my_next;
  logic signed [NW-1:0]     ex, ey, ez_next;
  logic signed [OW-1:0]     sx, wy, sy, sz;
  logic signed [31:0]       cl [3];

  function automatic logic [31:0] mag32(input logic signed [31:0] c);
    return c[31] ? 32'(-c) : 32'(c);
  endfunction

  // one restoring step: shift in a dividend bit, subtract if it fits
  function automatic logic [PW-1:0] div_step(input logic [PW-1:0] p, input logic [31:0] d);
    logic [PW-1:0] t;
    logic [32:0]   top;
    t   = p << 1;
    top = t[PW-1:DW];
    if (top >= {1'b0, d}) begin
      t[PW-1:DW] = top - {1'b0, d};
      t[0]       = 1'b1;
    end
    return t;
  endfunction

  assign ben = !out_valid || out_ready;
  assign pop = ben && !q_stat.empty;

  assign cl[0] = clip.x;
  assign cl[1] = clip.y;
  assign cl[2] = clip.z;

  always_comb begin
    logic [DW-1:0]        q;
    logic signed [DW:0]   qs;
    for (int l = 0; l < 3; l++) begin
      q  = pr[DW][l][DW-1:0];
      qs = {1'b0, q};
      if (neg[DW][l]) begin
        qs = -qs;
      end
      nd_next[l] = sat32(SAT_W'(qs));
    end
    ex      = NW'(nd[0]) + ONE_N;
    ey      = NW'(nd[1]) + ONE_N;
    ez_next = NW'(nd[2]) + ONE_N;
    mx_next = MW'(signed'({1'b0, cfg.vp_w})) * MW'(ex);
    my_next = MW'(signed'({1'b0, cfg.vp_h})) * MW'(ey);
    sx = (OW'(cfg.vp_x) <<< FRAC_BITS) + OW'(mx >>> 1);
    wy = (OW'(cfg.vp_y) <<< FRAC_BITS) + OW'(my >>> 1);
    sy = (OW'(signed'({1'b0, cfg.scr_h})) <<< FRAC_BITS) - wy;
    sz = OW'(ez >>> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DW; k++) begin
        vld[k] <= 1'b0;
      end
      n_vld     <= 1'b0;
      m_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (ben) begin
      vld[0] <= pop;
      for (int k = 1; k <= DW; k++) begin
        vld[k] <= vld[k-1];
      end
      n_vld     <= vld[DW];
      m_vld     <= n_vld;
      out_valid <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      zero[0] <= (clip.w == '0);
      dv[0]   <= mag32(clip.w);
      for (int l = 0; l < 3; l++) begin
        neg[0][l] <= cl[l][31] ^ clip.w[31];
        pr[0][l]  <= {33'd0, mag32(cl[l]), FRAC_BITS'(0)};
      end
      for (int k = 1; k <= DW; k++) begin
        zero[k] <= zero[k-1];
        neg[k]  <= neg[k-1];
        dv[k]   <= dv[k-1];
        for (int l = 0; l < 3; l++) begin
          pr[k][l] <= div_step(pr[k-1][l], dv[k-1]);
        end
      end
      n_zero <= zero[DW];
      for (int l = 0; l < 3; l++) begin
        nd[l] <= nd_next[l];
      end
      m_zero <= n_zero;
      mx     <= mx_next;
      my     <= my_next;
      ez     <= ez_next;
      if (m_zero) begin
        screen_x     <= '0;
        screen_y     <= '0;
        screen_depth <= '0;
        result_valid <= 1'b0;
      end else begin
        screen_x     <= sat32(SAT_W'(sx));
        screen_y     <= sat32(SAT_W'(sy));
        screen_depth <= sat32(SAT_W'(sz));
        result_valid <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/vertex_world_to_screen_projection_unit.sv @@
// top level of the world to screen projection unit: viewport registers and glue
// depends on vwsp_pkg, vwsp_front, vwsp_fifo, vwsp_back and the macros header
`timescale 1ns / 1ps
//
// usage
//   input channel (in_valid/in_ready): one word per item; mode selects a
//   modelview load, a projection load or a vertex projection. loads give no
//   result, each vertex gives exactly one word on the output channel
//   (out_valid/out_ready) with screen_x, screen_y, screen_depth and
//   result_valid (low when clip w is zero, coordinates then zero)
//   viewport registers are to be written through cfg_we/cfg_index/cfg_data
//   only while idle, by the user; the block itself does not enforce this
// throughput
//   one item per cycle unless stalled; the divider resolves one bit per stage
//   a projection load right after a vertex waits while that vertex forms
//   its eye coordinates
// reset
//   both matrices return to identity, viewport to 0, 0, 1024 by 768, screen
//   height 768, and all pipelines empty
// stalls
//   a stalled receiver holds the back end; a four-word queue lets the front
//   end keep taking items until it fills
//
`include "vertex_world_to_screen_projection_unit_macros.svh"

module vertex_world_to_screen_projection_unit import vwsp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] vertex_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic signed [31:0] screen_depth,
  output logic               result_valid,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  view_cfg_t cfg;
  clip_t     f_clip, q_clip;
  logic      f_vld, push, pop;
  q_stat_t   q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vp_x  <= '0;
      cfg.vp_y  <= '0;
      cfg.vp_w  <= CFG_W'(1024);
      cfg.vp_h  <= CFG_W'(768);
      cfg.scr_h <= CFG_W'(768);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VP_X:  cfg.vp_x  <= cfg_data;
        REG_VP_Y:  cfg.vp_y  <= cfg_data;
        REG_VP_W:  cfg.vp_w  <= cfg_data;
        REG_VP_H:  cfg.vp_h  <= cfg_data;
        REG_SCR_H: cfg.scr_h <= cfg_data;
        default: ;
      endcase
    end
  end

  assign push = f_vld && !q_stat.full;

  vwsp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .vertex_x   (vertex_x),
    .vertex_y   (vertex_y),
    .vertex_z   (vertex_z),
    .clip       (f_clip),
    .clip_vld   (f_vld),
    .q_full     (q_stat.full)
  );

  vwsp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (f_clip),
    .pop       (pop),
    .pop_data  (q_clip),
    .stat      (q_stat)
  );

  vwsp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .clip         (q_clip),
    .q_stat       (q_stat),
    .pop          (pop),
    .cfg          (cfg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .screen_depth (screen_depth),
    .result_valid (result_valid)
  );

  `VWSP_CHK_NOW(a_push_room, clk, rst, push, !q_stat.full, "queue written while full")
  `VWSP_CHK_NOW(a_pop_data, clk, rst, pop, !q_stat.empty, "queue read while empty")
  `VWSP_CHK_NEXT(a_push_lands, clk, rst, push, !q_stat.empty, "pushed word missing from queue")
  `VWSP_CHK_NOW(a_invalid_zero, clk, rst, out_valid && !result_valid,
    screen_x == 0 && screen_y == 0 && screen_depth == 0, "zero w word has coordinates")

endmodule

@@ dv/tb_vertex_world_to_screen_projection_unit.sv @@
// testbench for the world to screen projection unit: random and directed words
// with a fixed point predictor and an in-order scoreboard; depends on vwsp_pkg
`timescale 1ns / 1ps

module tb_vertex_world_to_screen_projection_unit;
  import vwsp_pkg::*;

  localparam int FB = 16;
  localparam int ONE = 1 << FB;
  localparam int LIMIT = 400000;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic               ok;
  } screen_word_t;

  int errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic longint floor_sh(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  class projection_scoreboard;
    longint mv[16];
    longint pj[16];
    longint vpx, vpy, vpw, vph, scrh;
    screen_word_t pending[$];

    function new();
      for (int i = 0; i < 16; i++) begin
        mv[i] = (i % 5 == 0) ? ONE : 0;
        pj[i] = mv[i];
      end
      vpx = 0; vpy = 0; vpw = 1024; vph = 768; scrh = 768;
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [CFG_W-1:0] d);
      case (idx)
        REG_VP_X:  vpx = longint'($signed(d));
        REG_VP_Y:  vpy = longint'($signed(d));
        REG_VP_W:  vpw = longint'(d);
        REG_VP_H:  vph = longint'(d);
        REG_SCR_H: scrh = longint'(d);
        default: ;
      endcase
    endfunction

    function void note_input(input logic [1:0] md, input logic [3:0] ci,
                             input logic signed [31:0] cv, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic signed [31:0] z);
      longint v[3], eye[4], clip[4], acc, nx, ny, nz, wy;
      screen_word_t r;
      if (md == MODE_MV) mv[ci] = cv;
      else if (md == MODE_PROJ) pj[ci] = cv;
      else if (md == MODE_VTX) begin
        v[0] = x; v[1] = y; v[2] = z;
        for (int i = 0; i < 4; i++) begin
          acc = mv[12 + i];
          for (int j = 0; j < 3; j++) acc += floor_sh(mv[j*4 + i] * v[j], FB);
          eye[i] = clamp32(acc);
        end
        for (int i = 0; i < 4; i++) begin
          acc = 0;
          for (int j = 0; j < 4; j++) acc += floor_sh(pj[j*4 + i] * eye[j], FB);
          clip[i] = clamp32(acc);
        end
        if (clip[3] == 0) begin
          r.sx = 0; r.sy = 0; r.sz = 0; r.ok = 0;
        end else begin
          nx = clamp32((clip[0] * ONE) / clip[3]);
          ny = clamp32((clip[1] * ONE) / clip[3]);
          nz = clamp32((clip[2] * ONE) / clip[3]);
          r.sx = 32'(clamp32(vpx * ONE + floor_sh(vpw * (nx + ONE), 1)));
          wy = vpy * ONE + floor_sh(vph * (ny + ONE), 1);
          r.sy = 32'(clamp32(scrh * ONE - wy));
          r.sz = 32'(clamp32(floor_sh(nz + ONE, 1)));
          r.ok = 1;
        end
        pending.push_back(r);
      end
    endfunction

    task check_result(input screen_word_t got);
      screen_word_t e;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (got.sx !== e.sx) report("screen_x", longint'(got.sx), longint'(e.sx));
      if (got.sy !== e.sy) report("screen_y", longint'(got.sy), longint'(e.sy));
      if (got.sz !== e.sz) report("screen_depth", longint'(got.sz), longint'(e.sz));
      if (got.ok !== e.ok) report("result_valid", longint'(got.ok), longint'(e.ok));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, result_valid;
  logic [1:0] mode = MODE_NONE;
  logic [3:0] coef_index = 0;
  logic signed [31:0] coef_value = 0, vertex_x = 0, vertex_y = 0, vertex_z = 0;
  logic signed [31:0] screen_x, screen_y, screen_depth;
  logic cfg_we = 0;
  logic [2:0] cfg_index = REG_VP_X;
  logic [CFG_W-1:0] cfg_data = 0;
  int send_idle = 0, recv_idle = 0;
  int cycles = 0;
  projection_scoreboard board = new();

  vertex_world_to_screen_projection_unit #(.FRAC_BITS(FB)) DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst && out_valid && out_ready)
      board.check_result('{screen_x, screen_y, screen_depth, result_valid});
  end

  // receiver stalls at random
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  task automatic send_word(input logic [1:0] md, input logic [3:0] ci,
                           input logic signed [31:0] cv, input logic signed [31:0] x,
                           input logic signed [31:0] y, input logic signed [31:0] z);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; mode <= md; coef_index <= ci; coef_value <= cv;
    vertex_x <= x; vertex_y <= y; vertex_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(md, ci, cv, x, y, z);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (FB + 50) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] d);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    board.set_reg(idx, d);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(ONE * 4)) - 32'sd131072;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(ONE * 200)) - 32'sd6553600;
    endcase
  endfunction

  task automatic random_items(input int n);
    int m;
    for (int k = 0; k < n; k++) begin
      m = $urandom_range(99);
      if (m < 4)
        send_word(MODE_NONE, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
      else if (m < 14)
        send_word(MODE_MV, 4'($urandom), rand_val(), $urandom, $urandom, $urandom);
      else if (m < 24)
        send_word(MODE_PROJ, 4'($urandom), rand_val(), $urandom, $urandom, $urandom);
      else
        send_word(MODE_VTX, 4'($urandom), $urandom, rand_val(), rand_val(), rand_val());
    end
  endtask

  task automatic random_view();
    write_reg(REG_VP_X, CFG_W'($urandom));
    write_reg(REG_VP_Y, CFG_W'($urandom));
    write_reg(REG_VP_W, CFG_W'($urandom_range(4096)));
    write_reg(REG_VP_H, CFG_W'($urandom_range(4096)));
    write_reg(REG_SCR_H, CFG_W'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: identity path, extremes, zero w, ignored mode
    send_word(MODE_VTX, 0, 0, 0, 0, 0);
    send_word(MODE_VTX, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_word(MODE_VTX, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_word(MODE_NONE, 4'hf, 32'sh7fffffff, 1, 2, 3);
    send_word(MODE_PROJ, 15, 0, 32'sh7fffffff, 0, 0);
    send_word(MODE_VTX, 0, 0, ONE, ONE, ONE);
    send_word(MODE_PROJ, 11, -ONE, 0, 0, 0);
    send_word(MODE_PROJ, 10, 32'sh80000000, 0, 0, 0);
    send_word(MODE_VTX, 0, 0, ONE, -ONE, ONE * 2);
    send_word(MODE_MV, 12, 32'sh7fffffff, 0, 0, 0);
    send_word(MODE_MV, 0, 32'sh80000000, 0, 0, 0);
    send_word(MODE_VTX, 15, 32'sh7fffffff, ONE, ONE, -ONE);
    send_word(MODE_VTX, 0, 0, 0, 0, 0);
    drain();
    write_reg(REG_VP_X, 13'h1000);
    write_reg(REG_VP_Y, 13'h0fff);
    write_reg(REG_VP_W, 13'd4096);
    write_reg(REG_VP_H, 13'd1);
    write_reg(REG_SCR_H, 13'd0);
    send_word(MODE_VTX, 0, 0, ONE, ONE, ONE);
    send_word(MODE_VTX, 0, 0, -ONE, 32'sh7fffffff, 0);
    for (int i = 0; i < 16; i++) begin
      send_word(MODE_MV, 4'(i), (i % 5 == 0) ? ONE : 0, 0, 0, 0);
      send_word(MODE_PROJ, 4'(i), (i % 5 == 0) ? ONE : 0, 0, 0, 0);
    end
    drain();
    send_idle = 16; recv_idle = 66;
    random_view();
    random_items(250);
    drain();
    send_idle = 66; recv_idle = 16;
    random_view();
    random_items(250);
    drain();
    send_idle = 0; recv_idle = 0;
    write_reg(REG_VP_X, 13'h0fff);
    write_reg(REG_VP_Y, 13'h1000);
    write_reg(REG_VP_W, 13'd1);
    write_reg(REG_VP_H, 13'd4096);
    write_reg(REG_SCR_H, 13'd4096);
    random_items(250);
    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/vwsp_pkg.sv
rtl/core/vwsp_front.sv
rtl/core/vwsp_fifo.sv
rtl/core/vwsp_back.sv
rtl/core/vertex_world_to_screen_projection_unit.sv
dv/tb_vertex_world_to_screen_projection_unit.sv
